[rtl/core/xee_pkg.sv]
package xee_pkg;

	// width of the running output position
	localparam int LENGTH_BITS = 16;
	// fixed field widths
	localparam int BYTE_W = 8;
	localparam int OUT_LEN_W = 16;
	localparam int CAP_W = 16;
	// compare width: holds position plus the longest entity without wrapping
	localparam int CMP_W = ((LENGTH_BITS > CAP_W) ? LENGTH_BITS : CAP_W) + 2;

	// configuration port
	localparam int PADDR_W = 2;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-1:0] ADDR_OUT_CAPACITY = PADDR_W'(0);
	localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(1024);

	// job queue
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	// result index within one job (up to six entity bytes plus status)
	localparam int IDX_W = 3;

	typedef enum logic [2:0] {
		ENT_NONE = 3'd0,
		ENT_LT   = 3'd1,
		ENT_GT   = 3'd2,
		ENT_AMP  = 3'd3,
		ENT_QUOT = 3'd4,
		ENT_APOS = 3'd5
	} ent_code_t;

	// one unit of back-end work: a run of bytes and/or the status word
	typedef struct packed {
		ent_code_t              code;
		logic [BYTE_W-1:0]      lit;
		logic                   has_chars;
		logic                   has_status;
		logic                   st;
		logic [OUT_LEN_W-1:0]   len;
	} job_t;

	function automatic ent_code_t classify(input logic [BYTE_W-1:0] b);
		ent_code_t c;
		case (b)
			8'h3c:   c = ENT_LT;
			8'h3e:   c = ENT_GT;
			8'h26:   c = ENT_AMP;
			8'h22:   c = ENT_QUOT;
			8'h27:   c = ENT_APOS;
			default: c = ENT_NONE;
		endcase
		return c;
	endfunction

	// bytes emitted for a code; a plain byte counts as one
	function automatic logic [IDX_W-1:0] ent_len(input ent_code_t c);
		logic [IDX_W-1:0] n;
		case (c)
			ENT_LT:   n = IDX_W'(4);
			ENT_GT:   n = IDX_W'(4);
			ENT_AMP:  n = IDX_W'(5);
			ENT_QUOT: n = IDX_W'(6);
			ENT_APOS: n = IDX_W'(6);
			default:  n = IDX_W'(1);
		endcase
		return n;
	endfunction

	function automatic logic [BYTE_W-1:0] ent_char(input ent_code_t c,
			input logic [IDX_W-1:0] idx, input logic [BYTE_W-1:0] lit);
		logic [47:0] s;
		logic [IDX_W-1:0] sel;
		logic [BYTE_W-1:0] r;
		s = 48'h0;
		sel = IDX_W'(5) - idx;
		case (c)
			ENT_LT:   s = {"&lt;", 16'h0};
			ENT_GT:   s = {"&gt;", 16'h0};
			ENT_AMP:  s = {"&amp;", 8'h0};
			ENT_QUOT: s = "&quot;";
			ENT_APOS: s = "&apos;";
			default:  s = 48'h0;
		endcase
		if (c == ENT_NONE) begin
			r = lit;
		end else begin
			r = s[{sel, 3'b000} +: 8];
		end
		return r;
	endfunction

endpackage

[rtl/core/xee_in_if.sv]
interface xee_in_if;
	logic       valid;
	logic       ready;
	logic       carries_byte;
	logic [7:0] in_byte;
	logic       in_last;

	modport source(output valid, carries_byte, in_byte, in_last, input ready);
	modport sink(input valid, carries_byte, in_byte, in_last, output ready);
endinterface

[rtl/core/xee_out_if.sv]
interface xee_out_if;
	logic        valid;
	logic        ready;
	logic [7:0]  out_byte;
	logic        is_status;
	logic        run_last;
	logic        status;
	logic [15:0] out_length;

	modport source(output valid, out_byte, is_status, run_last, status, out_length,
		input ready);
	modport sink(input valid, out_byte, is_status, run_last, status, out_length,
		output ready);
endinterface

[rtl/core/xee_front.sv]
module xee_front (
	input  logic                        clk,
	input  logic                        arst_n,
	xee_in_if.sink                      src,
	input  logic [xee_pkg::CAP_W-1:0]   capacity,
	input  logic                        q_full,
	output logic                        push,
	output xee_pkg::job_t               job
);
	import xee_pkg::*;

	logic [LENGTH_BITS-1:0] pos_q;
	logic                   ovf_q;

	logic [CMP_W-1:0]       pos_e, cap_e, sum_e;
	ent_code_t              code;
	logic                   active, fits, emit, ovf_nx, accept;
	logic [LENGTH_BITS-1:0] pos_nx;

	assign src.ready = !q_full;
	assign accept = src.valid && src.ready;

	always_comb begin
		code   = classify(src.in_byte);
		pos_e  = CMP_W'(pos_q);
		cap_e  = CMP_W'(capacity);
		sum_e  = pos_e + CMP_W'(ent_len(code));
		// room left below the terminator slot
		active = src.carries_byte && !ovf_q && (capacity != '0) &&
			(pos_e < cap_e - CMP_W'(1));
		fits   = (code == ENT_NONE) || (sum_e < cap_e);
		emit   = active && fits;
		ovf_nx = ovf_q || (active && !fits);
		pos_nx = emit ? LENGTH_BITS'(sum_e) : pos_q;
	end

	always_comb begin
		job.code       = code;
		job.lit        = src.in_byte;
		job.has_chars  = emit;
		job.has_status = src.in_last;
		job.st         = ovf_nx || (capacity == '0);
		job.len        = OUT_LEN_W'(pos_nx);
	end

	assign push = accept && (emit || src.in_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (src.in_last) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				pos_q <= pos_nx;
				ovf_q <= ovf_nx;
			end
		end
	end
endmodule

[rtl/core/xee_queue.sv]
module xee_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  xee_pkg::job_t  push_job,
	input  logic           pop,
	output logic           full,
	output logic           not_empty,
	output xee_pkg::job_t  head
);
	import xee_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full      = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end
endmodule

[rtl/core/xee_back.sv]
module xee_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  xee_pkg::job_t  head,
	output logic           pop,
	xee_out_if.source      res
);
	import xee_pkg::*;

	logic [IDX_W-1:0]     idx_q;
	logic                 out_v_q;
	logic [BYTE_W-1:0]    byte_q;
	logic                 stat_flag_q, run_last_q, st_q;
	logic [OUT_LEN_W-1:0] len_q;

	logic [IDX_W-1:0] n_chars, total;
	logic             adv, in_chars, last_res;

	always_comb begin
		n_chars  = head.has_chars ? ent_len(head.code) : '0;
		total    = n_chars + IDX_W'(head.has_status);
		in_chars = idx_q < n_chars;
		last_res = (idx_q == total - IDX_W'(1));
		adv      = q_valid && (!out_v_q || res.ready);
	end

	assign pop = adv && last_res;

	assign res.valid      = out_v_q;
	assign res.out_byte   = byte_q;
	assign res.is_status  = stat_flag_q;
	assign res.run_last   = run_last_q;
	assign res.status     = st_q;
	assign res.out_length = len_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			byte_q      <= in_chars ? ent_char(head.code, idx_q, head.lit) : '0;
			stat_flag_q <= !in_chars;
			run_last_q  <= last_res;
			st_q        <= in_chars ? 1'b0 : head.st;
			len_q       <= in_chars ? '0 : head.len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (adv) begin
				out_v_q <= 1'b1;
				idx_q   <= last_res ? '0 : idx_q + IDX_W'(1);
			end else if (res.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end
endmodule

[rtl/core/xml_entity_escaper_core.sv]
// An accepted word goes into the job queue, then into the back end's output register.
// The front takes one input word per cycle unless the queue is full; results leave at
// one word per cycle while res.ready is high, so an entity gives 4 to 6 words (plus status).
// The 4-entry job queue lets the front keep accepting while entities drain.
// Reset (arst_n low, asynchronous): position, error, queue and output cleared,
// out_capacity back to 1024.
module xml_entity_escaper_core (
	input  logic                          clk,
	input  logic                          arst_n,
	xee_in_if.sink                        src,
	xee_out_if.source                     res,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [xee_pkg::PADDR_W-1:0]   paddr,
	input  logic [xee_pkg::PDATA_W-1:0]   pwdata,
	output logic [xee_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import xee_pkg::*;

	logic [CAP_W-1:0] cap_q;

	// front to queue
	logic push;
	job_t push_job;
	logic q_full;
	// queue to back
	logic q_valid;
	logic pop;
	job_t head;

	// APB: zero-wait-state, write lands in the access phase
	assign pready = 1'b1;
	assign prdata = (paddr == ADDR_OUT_CAPACITY) ? PDATA_W'(cap_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAPACITY_RESET;
		end else if (psel && penable && pwrite && pready &&
				paddr == ADDR_OUT_CAPACITY) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// front: classify each byte, track position and error, queue the job
	xee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src),
		.capacity (cap_q),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	// short job queue decoupling classification from emission
	xee_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (q_full),
		.not_empty (q_valid),
		.head      (head)
	);

	// back: expands each job into result words behind an output register
	xee_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.head    (head),
		.pop     (pop),
		.res     (res)
	);
endmodule

[dv/tb_xml_entity_escaper_core.sv]
module tb_xml_entity_escaper_core;
	import xee_pkg::*;

	// characters that expand into entities
	localparam logic [7:0] CH_LT   = 8'h3c;
	localparam logic [7:0] CH_GT   = 8'h3e;
	localparam logic [7:0] CH_AMP  = 8'h26;
	localparam logic [7:0] CH_QUOT = 8'h22;
	localparam logic [7:0] CH_APOS = 8'h27;

	// capacity straight out of reset
	localparam logic [15:0] CAP_AT_RESET = 16'd1024;

	// settling time before a register write: the pipeline latency plus margin
	localparam int SETTLE_CYCLES = 6;
	localparam int MAX_REPORTS = 10;
	// input words to send over the whole run, and per random phase
	localparam int ITEM_TARGET = 330;
	localparam int PHASE_ITEMS = 38;

	// one result word as seen on the output channel
	typedef struct packed {
		logic [7:0]  data;
		logic        is_status;
		logic        run_last;
		logic        status;
		logic [15:0] length;
	} out_word_t;

	// directed table: either an input word or a capacity write
	typedef enum logic {
		ROW_WORD = 1'b0,
		ROW_CAP  = 1'b1
	} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		logic        cb;
		logic [7:0]  data;
		logic        last;
		logic        typed;   // status word given by hand below
		logic        st;
		logic [15:0] len;
		logic [15:0] cap;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;

	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	xee_in_if  src_ch ();
	xee_out_if res_ch ();

	xml_entity_escaper_core u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.src     (src_ch),
		.res     (res_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #5 clk = ~clk;

	// Predictor state: our own copy of capacity, write position and the
	// sticky overrun flag of the string in progress.
	logic [15:0] cap_model = CAP_AT_RESET;
	logic [15:0] write_pos = '0;
	logic        entity_overrun = 1'b0;

	// words the block still owes us, oldest first
	out_word_t due_words [$];

	int mismatches     = 0;
	int accepted_items = 0;
	int busy_items     = 0;   // accepted words that caused any output
	int checked_words  = 0;
	int cap_writes     = 0;
	int overrun_ends   = 0;
	// 0: no idling, 1: light, 2: heavy
	int idle_mode      = 0;

	function automatic void note_fail(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%s", msg);
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (idle_mode == 0)
			return 0;
		r = $urandom_range(0, 99);
		if (r < ((idle_mode == 2) ? 35 : 60))
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Work out what one accepted word must produce and queue it.
	// A byte is only considered while the string has not overrun and there is
	// room short of the terminator slot; an entity goes out whole or not at
	// all, and if it does not fit the rest of the string is thrown away.
	// The end of a string closes with a status word and clears the position.
	function automatic void predict_escape(input logic cb, input logic [7:0] b,
			input logic last);
		logic [47:0] text;
		int          elen;
		int          n;
		int          i;
		out_word_t   w;
		n = 0;
		text = '0;
		elen = 0;
		if (cb && !entity_overrun && cap_model != 0 &&
				int'(write_pos) < int'(cap_model) - 1) begin
			case (b)
				CH_LT: begin
					text = "&lt;";
					elen = 4;
				end
				CH_GT: begin
					text = "&gt;";
					elen = 4;
				end
				CH_AMP: begin
					text = "&amp;";
					elen = 5;
				end
				CH_QUOT: begin
					text = "&quot;";
					elen = 6;
				end
				CH_APOS: begin
					text = "&apos;";
					elen = 6;
				end
				default: elen = 0;
			endcase
			if (elen == 0) begin
				w = '{data: b, is_status: 1'b0, run_last: !last, status: 1'b0, length: 16'd0};
				due_words.push_back(w);
				write_pos = write_pos + 16'd1;
				n++;
			end else if (int'(write_pos) + elen < int'(cap_model)) begin
				for (i = 0; i < elen; i++) begin
					w = '{data: text[8*(elen-1-i) +: 8], is_status: 1'b0,
						run_last: (!last && i == elen - 1), status: 1'b0, length: 16'd0};
					due_words.push_back(w);
				end
				write_pos = write_pos + 16'(elen);
				n += elen;
			end else begin
				entity_overrun = 1'b1;
			end
		end
		if (last) begin
			w = '{data: 8'h00, is_status: 1'b1, run_last: 1'b1,
				status: (entity_overrun || cap_model == 0), length: write_pos};
			due_words.push_back(w);
			if (w.status)
				overrun_ends++;
			write_pos = '0;
			entity_overrun = 1'b0;
			n++;
		end
		if (n > 0)
			busy_items++;
	endfunction

	// Compare one output word against the oldest owed word, field by field.
	function automatic void check_word();
		out_word_t got;
		out_word_t want;
		got.data = res_ch.out_byte;
		got.is_status = res_ch.is_status;
		got.run_last = res_ch.run_last;
		got.status = res_ch.status;
		got.length = res_ch.out_length;
		checked_words++;
		if (due_words.size() == 0) begin
			note_fail($sformatf({"unowed word: byte=%02h is_status=%0b run_last=%0b",
				" status=%0b len=%0d"},
				got.data, got.is_status, got.run_last, got.status, got.length));
		end else begin
			want = due_words.pop_front();
			if (got.data !== want.data || got.is_status !== want.is_status ||
					got.run_last !== want.run_last || got.status !== want.status ||
					got.length !== want.length)
				note_fail($sformatf({"word %0d: want byte=%02h is_status=%0b run_last=%0b",
					" status=%0b len=%0d, got byte=%02h is_status=%0b run_last=%0b",
					" status=%0b len=%0d"}, checked_words,
					want.data, want.is_status, want.run_last, want.status, want.length,
					got.data, got.is_status, got.run_last, got.status, got.length));
		end
	endfunction

	// output side: sample on the edge, values are those from before it
	always @(posedge clk) begin
		if (arst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
			check_word();
	end

	// sink back-pressure: runs of ready with random stalls in between
	initial begin
		int hold;
		hold = 0;
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
				if ($urandom_range(0, 3) == 0)
					hold = pick_gap();
			end
		end
	end

	// Offer one word, wait for it to be taken, then predict. Always called on a
	// rising edge; valid is only dropped when a gap is wanted, so back-to-back
	// words keep it high.
	task automatic send_word(input logic cb, input logic [7:0] b, input logic last,
			input logic typed, input logic st, input logic [15:0] len);
		int        gap;
		out_word_t w;
		gap = pick_gap();
		if (gap > 0) begin
			src_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_ch.valid <= 1'b1;
		src_ch.carries_byte <= cb;
		src_ch.in_byte <= b;
		src_ch.in_last <= last;
		do @(posedge clk); while (src_ch.ready !== 1'b1);
		accepted_items++;
		predict_escape(cb, b, last);
		// hand-typed status word replaces the predicted one
		if (typed) begin
			w = due_words.pop_back();
			w.status = st;
			w.length = len;
			due_words.push_back(w);
		end
	endtask

	// Stop offering and wait until nothing is owed, then idle for as long as extra asks.
	// The loop waits on the clock before testing, so valid is never lowered and raised at once.
	task automatic drain_results(input int extra);
		src_ch.valid <= 1'b0;
		do @(posedge clk); while (due_words.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic apb_write(input logic [PADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= a;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// read the capacity back and hold it against our copy
	task automatic check_capacity_readback();
		logic [PDATA_W-1:0] rd;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_OUT_CAPACITY;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rd = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd !== PDATA_W'(cap_model))
			note_fail($sformatf("capacity readback: want %0d, got %0h", cap_model, rd));
	endtask

	// drains the block to idle before the write
	task automatic set_capacity(input logic [15:0] v);
		drain_results(SETTLE_CYCLES);
		apb_write(ADDR_OUT_CAPACITY, PDATA_W'(v));
		cap_model = v;
		cap_writes++;
		check_capacity_readback();
	endtask

	// Source characters: plenty of entity triggers, some text, the rest anything.
	function automatic logic [7:0] pick_char();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) begin
			case ($urandom_range(0, 4))
				0: return CH_LT;
				1: return CH_GT;
				2: return CH_AMP;
				3: return CH_QUOT;
				default: return CH_APOS;
			endcase
		end
		if (r < 55)
			return 8'($urandom_range(32, 126));
		return 8'($urandom_range(0, 255));
	endfunction

	// One well-formed string with the odd empty word mixed in. It closes either
	// on a last byte or on an empty end marker.
	task automatic send_string(input bit pause_mid);
		int n;
		int i;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 16);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				send_word(1'b0, 8'($urandom), 1'b0, 1'b0, 1'b0, '0);
			send_word(1'b1, pick_char(), 1'b0, 1'b0, 1'b0, '0);
			// sender holds off mid-string until the block has caught up
			if (pause_mid && i == n / 2)
				drain_results(0);
		end
		if ($urandom_range(0, 1) == 0)
			send_word(1'b1, pick_char(), 1'b1, 1'b0, 1'b0, '0);
		else
			send_word(1'b0, 8'($urandom), 1'b1, 1'b0, 1'b0, '0);
	endtask

	function automatic row_t word_row(input logic cb, input logic [7:0] b, input logic last);
		row_t r;
		r = '0;
		r.kind = ROW_WORD;
		r.cb = cb;
		r.data = b;
		r.last = last;
		return r;
	endfunction

	// string end whose status word is typed in
	function automatic row_t end_row(input logic cb, input logic [7:0] b, input logic st,
			input logic [15:0] len);
		row_t r;
		r = word_row(cb, b, 1'b1);
		r.typed = 1'b1;
		r.st = st;
		r.len = len;
		return r;
	endfunction

	function automatic row_t cap_row(input logic [15:0] v);
		row_t r;
		r = '0;
		r.kind = ROW_CAP;
		r.cap = v;
		return r;
	endfunction

	row_t directed [25];

	initial begin
		int phase;
		logic [15:0] cap_pick;
		arst_n <= 1'b0;
		src_ch.valid <= 1'b0;
		src_ch.carries_byte <= 1'b0;
		src_ch.in_byte <= '0;
		src_ch.in_last <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;

		directed = '{
			// empty string straight after reset
			end_row(1'b0, 8'h00, 1'b0, 16'd0),
			// byte extremes, plain text and all five entities at default size
			word_row(1'b1, 8'h00, 1'b0),
			word_row(1'b1, 8'hff, 1'b0),
			word_row(1'b1, 8'h41, 1'b0),
			word_row(1'b1, CH_LT, 1'b0),
			word_row(1'b1, CH_GT, 1'b0),
			word_row(1'b1, CH_AMP, 1'b0),
			word_row(1'b1, CH_QUOT, 1'b0),
			word_row(1'b1, CH_APOS, 1'b0),
			end_row(1'b1, 8'h80, 1'b0, 16'd29),
			// empty word without end: nothing comes out
			word_row(1'b0, 8'h55, 1'b0),
			// zero capacity: everything dropped, error reported
			cap_row(16'd0),
			word_row(1'b1, 8'h78, 1'b0),
			end_row(1'b1, CH_LT, 1'b1, 16'd0),
			// capacity one: only the terminator fits, silent drop
			cap_row(16'd1),
			end_row(1'b1, 8'h61, 1'b0, 16'd0),
			// entity too large: error, rest of string discarded
			cap_row(16'd5),
			word_row(1'b1, 8'h61, 1'b0),
			word_row(1'b1, 8'h62, 1'b0),
			word_row(1'b1, CH_AMP, 1'b0),
			end_row(1'b1, 8'h63, 1'b1, 16'd2),
			// destination full: an entity after that is dropped without error
			word_row(1'b1, CH_LT, 1'b0),
			word_row(1'b1, CH_AMP, 1'b0),
			end_row(1'b0, 8'h00, 1'b0, 16'd4),
			cap_row(16'd65535)
		};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_capacity_readback();

		// directed part: no idling so the sequences are easy to follow
		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CAP)
				set_capacity(directed[i].cap);
			else
				send_word(directed[i].cb, directed[i].data, directed[i].last,
					directed[i].typed, directed[i].st, directed[i].len);
		end

		// Random part in phases, each at its own capacity. Small sizes keep the
		// full and overrun paths busy; the extremes come round regularly.
		for (phase = 0; accepted_items < ITEM_TARGET && phase < 40; phase++) begin
			case (phase % 8)
				0: cap_pick = 16'($urandom_range(2, 24));
				1: cap_pick = 16'd65535;
				2: cap_pick = 16'd0;
				3: cap_pick = 16'($urandom_range(4, 12));
				4: cap_pick = 16'd1;
				5: cap_pick = 16'($urandom_range(25, 200));
				6: cap_pick = 16'd2;
				default: cap_pick = 16'($urandom_range(3, 1024));
			endcase
			set_capacity(cap_pick);
			idle_mode = (phase % 4 == 0) ? 0 : $urandom_range(1, 2);
			begin
				int phase_start;
				phase_start = accepted_items;
				while (accepted_items - phase_start < PHASE_ITEMS)
					send_string(phase == 1 && accepted_items == phase_start);
			end
		end

		drain_results(12);
		if (due_words.size() != 0)
			note_fail($sformatf("%0d words never arrived", due_words.size()));

		$display("run: %0d input words (%0d with output), %0d result words checked",
			accepted_items, busy_items, checked_words);
		$display("run: %0d capacity writes, %0d strings closed with error, %0d mismatches",
			cap_writes, overrun_ends, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#10000000;
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
rtl/core/xee_pkg.sv
rtl/core/xee_in_if.sv
rtl/core/xee_out_if.sv
rtl/core/xee_front.sv
rtl/core/xee_queue.sv
rtl/core/xee_back.sv
rtl/core/xml_entity_escaper_core.sv
dv/tb_xml_entity_escaper_core.sv
